@@ design/command_receiver_crc16_ack_defines.svh @@
// Assertion macros used by the command receiver core (cmdrx_core).
// Depends on nothing; the including module must have clk and rst_n.
`ifndef COMMAND_RECEIVER_CRC16_ACK_DEFINES_SVH
`define COMMAND_RECEIVER_CRC16_ACK_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define CMDRX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define CMDRX_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/cmdrx_pkg.sv @@
// Shared types and codes for the command receiver.
// No dependencies; imported by every module of the block.
package cmdrx_pkg;

    localparam logic [7:0]  OP_TRIGGER      = 8'h10;
    localparam logic [7:0]  OP_SET_INTERVAL = 8'h11;
    localparam logic [7:0]  REPLY_ACK       = 8'h06;
    localparam logic [7:0]  REPLY_NAK       = 8'h15;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [31:0] INTERVAL_RESET  = 32'd10000;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;

    // One request from the link side
    typedef struct packed {
        logic       tick;
        logic [7:0] rx_byte;
    } cmdrx_item_t;

    // One reply toward the host side
    typedef struct packed {
        logic [31:0] interval_ms;
        logic        interval_written;
        logic        trigger_pulse;
        logic [7:0]  reply_byte;
    } cmdrx_result_t;

endpackage

@@ design/command_receiver_crc16_ack.sv @@
// Path: a request is held in the input register while the parse/CRC logic loads its reply
// into the output register, from which the reply is presented.
// Throughput: one request per cycle; a reply held by the receiver stalls the input register.
// Reset (rst_n, async, low): parser idle, CRC 0xFFFF, interval 10000 ms, timeout 100 ticks.
// Depends on cmdrx_pkg, cmdrx_in_stage and cmdrx_core.
module command_receiver_crc16_ack
    import cmdrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,     // byte gap limit in millisecond ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    input  logic        s_axis_tuser,    // [0] opcode (1 = millisecond tick)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [7:0] reply_byte, [39:8] interval_ms
    output logic [1:0]  m_axis_tuser     // [0] trigger_pulse, [1] interval_written
);

    cmdrx_item_t   in_item;
    cmdrx_item_t   item;
    logic          item_valid;
    logic          step;
    logic          res_vld;
    cmdrx_result_t res;
    logic          out_vld_reg;
    logic          out_vld_next;
    cmdrx_result_t out_reg;

    assign in_item.tick    = s_axis_tuser;
    assign in_item.rx_byte = s_axis_tdata;

    // Process the held request whenever the output register can take a reply
    assign step = item_valid && (!out_vld_reg || m_axis_tready);

    cmdrx_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_item    (in_item),
        .in_ready   (s_axis_tready),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    cmdrx_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .item        (item),
        .res_vld     (res_vld),
        .res         (res)
    );

    // Output register: load a new reply, drop the taken one
    assign out_vld_next = (step && res_vld) || (out_vld_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_vld)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_reg.interval_ms, out_reg.reply_byte};
    assign m_axis_tuser  = {out_reg.interval_written, out_reg.trigger_pulse};

endmodule

@@ design/cmdrx_in_stage.sv @@
// Input register of the command receiver: holds one request for the core.
// Depends on cmdrx_pkg.
module cmdrx_in_stage
    import cmdrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cmdrx_item_t in_item,
    output logic        in_ready,
    input  logic        take,
    output logic        item_valid,
    output cmdrx_item_t item
);

    logic        vld_reg;
    logic        vld_next;
    cmdrx_item_t item_reg;

    // Accept when empty or when the held request moves on this cycle
    assign in_ready = !vld_reg || take;
    assign vld_next = in_valid ? 1'b1 : (vld_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next & (in_ready | vld_reg);
        end
    end

    // Load payload on each accepted request
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

@@ design/cmdrx_core.sv @@
// Command parser, CRC-16/CCITT-FALSE check, byte gap timer and interval register.
// Depends on cmdrx_pkg and the assertion macro header.
`include "command_receiver_crc16_ack_defines.svh"

module cmdrx_core
    import cmdrx_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    input  logic          step,
    input  cmdrx_item_t   item,
    output logic          res_vld,
    output cmdrx_result_t res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_SETI = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] gap_reg, gap_next;
    logic [31:0] interval_reg, interval_next;
    logic [15:0] timeout_reg;

    logic        collecting;
    logic [15:0] limit;
    logic [15:0] gap_inc;
    logic [15:0] crc_upd;
    logic [15:0] crc_got;

    // Fold one byte into the CRC, MSB first
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    assign collecting = (phase_reg == PH_TRIG) || (phase_reg == PH_SETI);
    assign limit      = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign gap_inc    = (gap_reg == 16'hFFFF) ? gap_reg : gap_reg + 16'd1;
    assign crc_upd    = crc_update(collecting ? crc_reg : CRC_INIT, item.rx_byte);
    assign crc_got    = {crc_high_reg, item.rx_byte};

    // Next state and reply for the request in the input register
    always_comb
    begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        crc_next         = crc_reg;
        crc_high_next    = crc_high_reg;
        shift_next       = shift_reg;
        gap_next         = gap_reg;
        interval_next    = interval_reg;
        res_vld          = 1'b0;
        res.reply_byte       = REPLY_NAK;
        res.trigger_pulse    = 1'b0;
        res.interval_written = 1'b0;

        if (item.tick)
        begin
            // Count the byte gap; drop the command and reply NAK on timeout
            if (collecting)
            begin
                gap_next = gap_inc;
                if (gap_inc >= limit)
                begin
                    phase_next      = PH_IDLE;
                    bytes_left_next = 3'd0;
                    crc_next        = CRC_INIT;
                    crc_high_next   = 8'd0;
                    shift_next      = 32'd0;
                    gap_next        = 16'd0;
                    res_vld         = 1'b1;
                end
            end
        end
        else if (!collecting)
        begin
            // Decode the opcode byte
            phase_next      = PH_IDLE;
            bytes_left_next = 3'd0;
            crc_next        = CRC_INIT;
            crc_high_next   = 8'd0;
            shift_next      = 32'd0;
            gap_next        = 16'd0;
            if (item.rx_byte == OP_TRIGGER)
            begin
                phase_next      = PH_TRIG;
                bytes_left_next = 3'd2;
                crc_next        = crc_upd;
            end
            else if (item.rx_byte == OP_SET_INTERVAL)
            begin
                phase_next      = PH_SETI;
                bytes_left_next = 3'd6;
                crc_next        = crc_upd;
            end
            else
            begin
                res_vld = 1'b1;
            end
        end
        else
        begin
            gap_next = 16'd0;
            if (bytes_left_reg > 3'd2)
            begin
                // Shift in payload and advance the CRC
                shift_next      = {shift_reg[23:0], item.rx_byte};
                crc_next        = crc_upd;
                bytes_left_next = bytes_left_reg - 3'd1;
            end
            else if (bytes_left_reg == 3'd2)
            begin
                crc_high_next   = item.rx_byte;
                bytes_left_next = 3'd1;
            end
            else
            begin
                // Final CRC byte: check and reply
                phase_next      = PH_IDLE;
                bytes_left_next = 3'd0;
                crc_next        = CRC_INIT;
                crc_high_next   = 8'd0;
                shift_next      = 32'd0;
                res_vld         = 1'b1;
                if (crc_got == crc_reg)
                begin
                    res.reply_byte = REPLY_ACK;
                    if (phase_reg == PH_TRIG)
                    begin
                        res.trigger_pulse = 1'b1;
                    end
                    else
                    begin
                        res.interval_written = 1'b1;
                        interval_next        = shift_reg;
                    end
                end
            end
        end

        res.interval_ms = interval_next;
    end

    // Hold parser state; advance once per processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= 3'd0;
            crc_reg        <= CRC_INIT;
            crc_high_reg   <= 8'd0;
            shift_reg      <= 32'd0;
            gap_reg        <= 16'd0;
            interval_reg   <= INTERVAL_RESET;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
            shift_reg      <= shift_next;
            gap_reg        <= gap_next;
            interval_reg   <= interval_next;
        end
    end

    // Timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    `CMDRX_ASSERT_IMPL(a_flags_exclusive, res_vld && res.trigger_pulse, !res.interval_written, "trigger and interval write in one reply")
    `CMDRX_ASSERT_IMPL(a_nak_clean, res_vld && (res.reply_byte == REPLY_NAK), !res.trigger_pulse && !res.interval_written, "NAK carries a command flag")
    `CMDRX_ASSERT_IMPL(a_idle_no_count, phase_reg == PH_IDLE, bytes_left_reg == 3'd0 && gap_reg == 16'd0, "idle with bytes or gap pending")
    `CMDRX_ASSERT_IMPL(a_trig_count, phase_reg == PH_TRIG, bytes_left_reg == 3'd1 || bytes_left_reg == 3'd2, "trigger command with bad byte count")

endmodule

@@ dv/command_receiver_crc16_ack_tb.sv @@
// Testbench for command_receiver_crc16_ack: streams bytes and millisecond ticks into the block,
// predicts every ACK/NAK reply in a scoreboard and checks each reply field as it leaves.
// Depends on cmdrx_pkg and the command_receiver_crc16_ack RTL.

class cmd_scoreboard;
    typedef enum logic [1:0] {RX_IDLE, RX_TRIGGER, RX_SET_INTERVAL} rx_phase_e;

    rx_phase_e   phase;
    logic [2:0]  bytes_left;
    logic [15:0] crc_accum;
    logic [7:0]  crc_high;
    logic [31:0] interval_shift;
    logic [15:0] gap_count;
    logic [31:0] interval_reg;
    logic [15:0] gap_limit;
    cmdrx_pkg::cmdrx_result_t pending_replies[$];
    int unsigned failures;

    function new();
        gap_limit     = cmdrx_pkg::TIMEOUT_RESET;
        interval_reg  = cmdrx_pkg::INTERVAL_RESET;
        failures      = 0;
        clear_command();
    endfunction

    // CRC-16/CCITT-FALSE, one byte, MSB first
    static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ cmdrx_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function void clear_command();
        phase          = RX_IDLE;
        bytes_left     = '0;
        crc_accum      = cmdrx_pkg::CRC_INIT;
        crc_high       = '0;
        interval_shift = '0;
        gap_count      = '0;
    endfunction

    function void add_reply(logic [7:0] code, logic trig, logic wr);
        cmdrx_pkg::cmdrx_result_t r;
        r.reply_byte       = code;
        r.trigger_pulse    = trig;
        r.interval_written = wr;
        r.interval_ms      = interval_reg;
        pending_replies.push_back(r);
    endfunction

    // Advance the parser by one accepted request and queue its reply, if any
    function void note_request(logic tick, logic [7:0] b);
        logic [15:0] limit;
        logic [31:0] new_interval;
        bit          collecting;
        bit          crc_ok;
        rx_phase_e   was;
        collecting = (phase == RX_TRIGGER) || (phase == RX_SET_INTERVAL);

        if (tick)
        begin
            if (!collecting)
                return;
            limit = (gap_limit == 16'd0) ? 16'd1 : gap_limit;
            if (gap_count != 16'hFFFF)
                gap_count++;
            if (gap_count >= limit)
            begin
                clear_command();
                add_reply(cmdrx_pkg::REPLY_NAK, 1'b0, 1'b0);
            end
            return;
        end

        // Opcode byte while idle
        if (!collecting)
        begin
            clear_command();
            if (b == cmdrx_pkg::OP_TRIGGER)
            begin
                phase      = RX_TRIGGER;
                bytes_left = 3'd2;
                crc_accum  = crc_update(cmdrx_pkg::CRC_INIT, b);
            end
            else if (b == cmdrx_pkg::OP_SET_INTERVAL)
            begin
                phase      = RX_SET_INTERVAL;
                bytes_left = 3'd6;
                crc_accum  = crc_update(cmdrx_pkg::CRC_INIT, b);
            end
            else
                add_reply(cmdrx_pkg::REPLY_NAK, 1'b0, 1'b0);
            return;
        end

        gap_count = '0;
        if (bytes_left > 3'd2)
        begin
            interval_shift = {interval_shift[23:0], b};
            crc_accum      = crc_update(crc_accum, b);
            bytes_left--;
        end
        else if (bytes_left == 3'd2)
        begin
            crc_high   = b;
            bytes_left = 3'd1;
        end
        else
        begin
            // Low CRC byte closes the command
            crc_ok       = ({crc_high, b} == crc_accum);
            was          = phase;
            new_interval = interval_shift;
            clear_command();
            if (!crc_ok)
                add_reply(cmdrx_pkg::REPLY_NAK, 1'b0, 1'b0);
            else if (was == RX_TRIGGER)
                add_reply(cmdrx_pkg::REPLY_ACK, 1'b1, 1'b0);
            else
            begin
                interval_reg = new_interval;
                add_reply(cmdrx_pkg::REPLY_ACK, 1'b0, 1'b1);
            end
        end
    endfunction

    // Compare one reply with the oldest prediction
    function void check_reply(cmdrx_pkg::cmdrx_result_t got);
        cmdrx_pkg::cmdrx_result_t want;
        if (pending_replies.size() == 0)
        begin
            $error("unexpected reply: reply_byte %0h, interval_ms %0d",
                   got.reply_byte, got.interval_ms);
            failures++;
            return;
        end
        want = pending_replies.pop_front();
        if (got.reply_byte !== want.reply_byte)
        begin
            $error("reply_byte mismatch: expected %0h, got %0h",
                   want.reply_byte, got.reply_byte);
            failures++;
        end
        if (got.trigger_pulse !== want.trigger_pulse)
        begin
            $error("trigger_pulse mismatch: expected %0b, got %0b",
                   want.trigger_pulse, got.trigger_pulse);
            failures++;
        end
        if (got.interval_written !== want.interval_written)
        begin
            $error("interval_written mismatch: expected %0b, got %0b",
                   want.interval_written, got.interval_written);
            failures++;
        end
        if (got.interval_ms !== want.interval_ms)
        begin
            $error("interval_ms mismatch: expected %0d, got %0d",
                   want.interval_ms, got.interval_ms);
            failures++;
        end
    endfunction
endclass

module command_receiver_crc16_ack_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cmdrx_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT   = 5000;
    localparam int unsigned REQUESTS_PER_RUN = 245;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] rx_byte
    logic        s_axis_tuser;     // [0] opcode (1 = millisecond tick)
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;     // [7:0] reply_byte, [39:8] interval_ms
    logic [1:0]  m_axis_tuser;     // [0] trigger_pulse, [1] interval_written

    int          sender_idle_pct;
    int          receiver_stall_pct;
    int unsigned requests_sent;
    int unsigned idle_cycles;
    cmd_scoreboard sb = new();

    command_receiver_crc16_ack u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the reply side at random
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Sample both handshakes at the edge
    always @(posedge clk)
    begin : monitor
        cmdrx_result_t observed;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                observed.reply_byte       = m_axis_tdata[7:0];
                observed.interval_ms      = m_axis_tdata[39:8];
                observed.trigger_pulse    = m_axis_tuser[0];
                observed.interval_written = m_axis_tuser[1];
                sb.check_reply(observed);
            end
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata);
        end
    end

    // Count cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Present one request, with a random idle gap first, and hold it until taken
    task automatic send_request(input logic tick, input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= tick;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic drive_tick();
        send_request(1'b1, 8'($urandom));
    endtask

    // Send a full command frame, ticks sprinkled between bytes
    task automatic send_command(input logic [7:0] op, input logic [31:0] value,
                                input bit corrupt, input int tick_pct);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        frame.push_back(op);
        if (op == OP_SET_INTERVAL)
        begin
            frame.push_back(value[31:24]);
            frame.push_back(value[23:16]);
            frame.push_back(value[15:8]);
            frame.push_back(value[7:0]);
        end
        crc = CRC_INIT;
        foreach (frame[i])
            crc = sb.crc_update(crc, frame[i]);
        if (corrupt)
            crc = crc ^ (16'h0001 << $urandom_range(15));
        frame.push_back(crc[15:8]);
        frame.push_back(crc[7:0]);
        foreach (frame[i])
        begin
            while ($urandom_range(99) < tick_pct)
                drive_tick();
            send_request(1'b0, frame[i]);
        end
    endtask

    // Hold the request side and let the block drain
    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        wait_for_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.gap_limit = ticks;
    endtask

    initial
    begin : stimulus
        int          sel;
        int unsigned run_start;
        int unsigned closing_ticks;
        logic [31:0] interval_value;
        logic [15:0] timeout_plan [8];

        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        requests_sent      = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick while idle, unknown opcodes, good and bad commands
        drive_tick();
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hFF);
        send_command(OP_TRIGGER, '0, 1'b0, 0);
        send_command(OP_TRIGGER, '0, 1'b1, 0);
        send_command(OP_SET_INTERVAL, 32'hFFFF_FFFF, 1'b0, 0);

        // Byte gap timeout at the shortest limit, then with the register at zero
        write_timeout(16'd1);
        send_request(1'b0, OP_SET_INTERVAL);
        drive_tick();
        write_timeout(16'd0);
        send_request(1'b0, OP_TRIGGER);
        drive_tick();

        // Random runs, one timeout setting and one idle profile each
        timeout_plan = '{16'd65535, 16'd2, 16'd1, 16'd0, 16'd3, 16'd100, 16'd5, 16'd65535};
        for (int run = 0; run < 8; run++)
        begin
            write_timeout(timeout_plan[run]);
            case (run % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
                default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
            endcase
            closing_ticks = (timeout_plan[run] <= 16'd5) ? timeout_plan[run] + 1 : 0;
            run_start = requests_sent;

            while (requests_sent - run_start < REQUESTS_PER_RUN)
            begin
                sel = $urandom_range(99);
                case ($urandom_range(3))
                    0: interval_value = 32'h0000_0000;
                    1: interval_value = 32'hFFFF_FFFF;
                    2: interval_value = $urandom_range(65535);
                    default: interval_value = $urandom;
                endcase

                if (sel < 65)
                begin
                    // well-formed frame, some with a damaged CRC
                    send_command(($urandom_range(1) != 0) ? OP_SET_INTERVAL : OP_TRIGGER,
                                 interval_value, ($urandom_range(99) < 15), 6);
                end
                else if (sel < 77)
                    send_request(1'b0, 8'($urandom));
                else if (sel < 87)
                begin
                    repeat ($urandom_range(1, 4)) drive_tick();
                end
                else
                begin
                    // truncated frame, left to time out where the limit is short
                    send_request(1'b0, ($urandom_range(1) != 0) ? OP_SET_INTERVAL : OP_TRIGGER);
                    repeat ($urandom_range(0, 4)) send_request(1'b0, 8'($urandom));
                    repeat (closing_ticks) drive_tick();
                end
            end
        end

        wait_for_replies();
        repeat (4) @(posedge clk);
        if (sb.failures == 0 && sb.pending_replies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
